// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// ===== hw/rtl/spimf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package spimf_pkg;

  typedef enum logic [2:0] {
    REQ_WRITE  = 3'd0,
    REQ_READ   = 3'd1,
    REQ_SELECT = 3'd2,
    REQ_SLAVE  = 3'd3,
    REQ_TICK   = 3'd4
  } req_t;

  localparam logic [1:0] ADDR_STATUS  = 2'd0;
  localparam logic [1:0] ADDR_CONTROL = 2'd1;
  localparam logic [1:0] ADDR_DATA    = 2'd2;

  localparam int CTL_SSIG = 7;
  localparam int CTL_SPEN = 6;
  localparam int CTL_MSTR = 4;
  localparam int STAT_DONE = 7;
  localparam int STAT_COL  = 6;

  localparam logic [7:0] CTL_RESET = 8'h04;
  localparam int TICK_W = 9;
  localparam logic [TICK_W-1:0] TICKS_BASE = 9'd32;

  typedef struct packed {
    req_t       req_type;
    logic [1:0] reg_addr;
    logic [7:0] write_data;
    logic       select_pin;
    logic [7:0] slave_byte;
    logic [7:0] partner_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       sent_valid;
    logic [7:0] sent_byte;
    logic       busy_res;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spi_controller_with_mode_fault.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  tdata fields (low bit up)                                     tuser
// s_axis   in   reg_addr[1:0] write_data[9:2] select_pin[10]                  req_type
//               slave_byte[18:11] partner_byte[26:19], zero pad to 32
// m_axis   out  read_data[7:0] irq[8] sent_byte[16:9] busy_res[17], pad to 24 sent_valid
//
// One word per clock sustained while the output is not stalled: an accepted word sits in the
// input register, then updates the register file as its result is registered.
// Synchronous reset puts status 0, control 0x04, data 0, select level high.
// A stalled result holds; the input register still takes one more word.
module spi_controller_with_mode_fault (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // reg_addr, write_data, select_pin, slave_byte,
                                          // partner_byte
  input  wire logic [2:0]  s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // read_data, irq, sent_byte, busy_res
  output logic             m_axis_tuser   // sent_valid
);
  import spimf_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  result_t step_res;
  result_t out_res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.req_type     <= req_t'(s_axis_tuser);
      in_item.reg_addr     <= s_axis_tdata[1:0];
      in_item.write_data   <= s_axis_tdata[9:2];
      in_item.select_pin   <= s_axis_tdata[10];
      in_item.slave_byte   <= s_axis_tdata[18:11];
      in_item.partner_byte <= s_axis_tdata[26:19];
    end
  end

  spimf_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tdata = {6'b0, out_res.busy_res, out_res.sent_byte, out_res.irq,
                         out_res.read_data};
  assign m_axis_tuser = out_res.sent_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/spimf_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spimf_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire spimf_pkg::item_t  item,
  output spimf_pkg::result_t     res
);
  import spimf_pkg::*;

  logic              done_flag, done_flag_next;
  logic              collision_flag, collision_flag_next;
  logic [7:0]        control_reg, control_reg_next;
  logic [7:0]        data_reg, data_reg_next;
  logic [7:0]        shift_out_byte, shift_out_byte_next;
  logic [TICK_W-1:0] ticks_left, ticks_left_next;
  logic              transfer_on, transfer_on_next;
  logic              select_level, select_level_next;

  always_comb begin
    done_flag_next      = done_flag;
    collision_flag_next = collision_flag;
    control_reg_next    = control_reg;
    data_reg_next       = data_reg;
    shift_out_byte_next = shift_out_byte;
    ticks_left_next     = ticks_left;
    transfer_on_next    = transfer_on;
    select_level_next   = select_level;
    res                 = '0;
    unique case (item.req_type)
      REQ_WRITE: begin
        unique case (item.reg_addr)
          ADDR_STATUS: begin
            if (item.write_data[STAT_DONE]) done_flag_next = 1'b0;
            if (item.write_data[STAT_COL]) collision_flag_next = 1'b0;
          end
          ADDR_CONTROL: begin
            control_reg_next = item.write_data;
            if (!item.write_data[CTL_SPEN]) begin
              transfer_on_next = 1'b0;
              ticks_left_next  = '0;
            end else if (!item.write_data[CTL_SSIG] && item.write_data[CTL_MSTR]
                         && !select_level) begin
              control_reg_next[CTL_MSTR] = 1'b0;
              done_flag_next             = 1'b1;
            end
          end
          ADDR_DATA: begin
            if (transfer_on) begin
              collision_flag_next = 1'b1;
            end else begin
              data_reg_next = item.write_data;
              if (control_reg[CTL_SPEN] && control_reg[CTL_MSTR]) begin
                shift_out_byte_next = item.write_data;
                ticks_left_next     = TICKS_BASE << control_reg[1:0];
                transfer_on_next    = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      REQ_READ: begin
        unique case (item.reg_addr)
          ADDR_STATUS:  res.read_data = {done_flag, collision_flag, 6'b0};
          ADDR_CONTROL: res.read_data = control_reg;
          ADDR_DATA:    res.read_data = data_reg;
          default:      res.read_data = 8'h00;
        endcase
      end
      REQ_SELECT: begin
        select_level_next = item.select_pin;
        if (control_reg[CTL_SPEN] && !control_reg[CTL_SSIG] && control_reg[CTL_MSTR]
            && !item.select_pin) begin
          control_reg_next[CTL_MSTR] = 1'b0;
          done_flag_next             = 1'b1;
        end
      end
      REQ_SLAVE: begin
        if (control_reg[CTL_SPEN] && !control_reg[CTL_MSTR]
            && (control_reg[CTL_SSIG] || !select_level)) begin
          data_reg_next  = item.slave_byte;
          done_flag_next = 1'b1;
        end
      end
      REQ_TICK: begin
        if (transfer_on) begin
          if (ticks_left <= TICK_W'(1)) begin
            ticks_left_next  = '0;
            transfer_on_next = 1'b0;
            // master may have been dropped mid-transfer: then no exchange
            if (control_reg[CTL_SPEN] && control_reg[CTL_MSTR]) begin
              data_reg_next  = item.partner_byte;
              done_flag_next = 1'b1;
              res.sent_valid = 1'b1;
              res.sent_byte  = shift_out_byte;
            end
          end else begin
            ticks_left_next = ticks_left - TICK_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    res.irq      = done_flag_next;
    res.busy_res = transfer_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_flag      <= 1'b0;
      collision_flag <= 1'b0;
      control_reg    <= CTL_RESET;
      data_reg       <= 8'h00;
      shift_out_byte <= 8'h00;
      ticks_left     <= '0;
      transfer_on    <= 1'b0;
      select_level   <= 1'b1;
    end else if (step) begin
      done_flag      <= done_flag_next;
      collision_flag <= collision_flag_next;
      control_reg    <= control_reg_next;
      data_reg       <= data_reg_next;
      shift_out_byte <= shift_out_byte_next;
      ticks_left     <= ticks_left_next;
      transfer_on    <= transfer_on_next;
      select_level   <= select_level_next;
    end
  end

  `ASSERT_IMPLY(a_busy_has_ticks, clk, rst, transfer_on, ticks_left != '0)
  `ASSERT_IMPLY(a_idle_no_ticks, clk, rst, !transfer_on, ticks_left == '0)
  `ASSERT_NEXT(a_irq_tracks_done, clk, rst, step, done_flag == $past(res.irq))
  `ASSERT_NEXT(a_sent_sets_done, clk, rst, step && res.sent_valid, done_flag && !transfer_on)

endmodule
`default_nettype wire
